// ----- design/mlp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlp_pkg: shared types and constants for the MLP inference engine
// Holds sizes, operation codes, layer descriptor layout and a 32-bit
// saturation helper.
// ----------------------------------------------------------------------------
package mlp_pkg;
   localparam int MaxLayers = 8;
   localparam int MaxDim    = 64;
   localparam int FracBits  = 16;
   localparam int LayW      = $clog2(MaxLayers);
   localparam int DimW      = $clog2(MaxDim);
   localparam int LenW      = DimW + 1;
   localparam int AccW      = 80;

   typedef enum logic [1:0] {
      OP_DESC   = 2'd0,
      OP_WEIGHT = 2'd1,
      OP_BIAS   = 2'd2,
      OP_ELEM   = 2'd3
   } op_type;

   typedef struct packed {
      logic            relu;
      logic [LenW-1:0] size;
   } desc_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] hi_lim;
      logic signed [AccW-1:0] lo_lim;
      hi_lim = AccW'(signed'(32'sh7FFFFFFF));
      lo_lim = -AccW'(signed'(33'sh080000000));
      if (v > hi_lim)      sat32 = 32'sh7FFFFFFF;
      else if (v < lo_lim) sat32 = 32'sh80000000;
      else                 sat32 = v[31:0];
   endfunction
endpackage

// ----- design/mlp_forward_pass.sv -----
// ----------------------------------------------------------------------------
// mlp_forward_pass: fixed-point multilayer network inference engine
// Stores layers, weights and biases in on-chip memories and runs the
// network forward from a staged input vector, one multiply per cycle.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake     | Contents
// req_    | in  | valid / stall | operation, layer, row, col, value, ...
// rsp_    | out | valid / stall | index, result, final_res
// csr_    | in  | valid / ready | layer_count
//
// Loads and non-last elements only write memory. A run copies the whole staged
// vector, then per layer reads the descriptor and either computes each output
// of an affine layer on the single weight read port and multiplier or clamps
// each element of a ReLU layer, and moves the whole next vector back. One more
// descriptor step ends the walk, then results leave one per cycle unless the
// receiver stalls. Reset is synchronous and clears control only; memories are
// undefined until written. A stalled result holds; no item is taken during a run.
// ----------------------------------------------------------------------------
module mlp_forward_pass (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [2:0]          req_layer,
   input  logic [5:0]          req_row,
   input  logic [5:0]          req_col,
   input  logic signed [31:0]  req_value,
   input  logic                req_is_relu,
   input  logic [6:0]          req_out_size,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [5:0]          rsp_index,
   output logic signed [31:0]  rsp_result,
   output logic                rsp_final_res,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_layer_count
);
   import mlp_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_COPY  = 8'b00000010,
      S_LAYER = 8'b00000100,
      S_MAC   = 8'b00001000,
      S_FIN   = 8'b00010000,
      S_RELU  = 8'b00100000,
      S_EMIT  = 8'b01000000,
      S_SWAP  = 8'b10000000
   } st_type;

   // memories
   logic signed [31:0] wmem [MaxLayers*MaxDim*MaxDim];
   logic signed [31:0] bmem [MaxLayers*MaxDim];
   desc_type           dmem [MaxLayers];
   logic signed [31:0] vin  [MaxDim];  // staged input
   logic signed [31:0] va   [MaxDim];  // working vector
   logic signed [31:0] vb   [MaxDim];  // next vector

   st_type               st_ff, st_in;
   logic [3:0]           cnt_ff;
   logic [LenW-1:0]      len_ff, len_in;
   logic [LayW:0]        lay_ff, lay_in;
   logic [LenW-1:0]      n_ff, n_in;
   logic [LenW-1:0]      i_ff, i_in;
   logic [LenW-1:0]      j_ff, j_in;
   logic [1:0]           ph_ff, ph_in;
   logic signed [AccW-1:0] acc_ff, acc_in;
   logic signed [63:0]   prod_ff;
   logic signed [31:0]   wrd_ff, vrd_ff, brd_ff;
   logic                 prod_v_ff, prod_v_in;
   logic                 pv1_ff;
   logic                 rv_ff;
   logic [5:0]           ri_ff;
   logic signed [31:0]   rr_ff;
   logic                 rf_ff;
   logic [LayW:0]        cnt_used;
   logic                 req_acc;
   logic                 vb_we;
   logic signed [31:0]   vb_wd;
   logic [DimW-1:0]      vb_wa;
   logic signed [31:0]   vin_rd_ff, vb_rd_ff;
   logic [DimW-1:0]      cpa_ff;
   logic                 cpsel_ff;
   logic                 cpv_ff;

   assign csr_ready = 1'b1;
   assign req_stall = (st_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign cnt_used  = (cnt_ff > 4'(MaxLayers)) ? (LayW+1)'(MaxLayers) : cnt_ff[LayW:0];

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 4'd1;
      else if (csr_valid && csr_ready) cnt_ff <= csr_layer_count;
   end

   // load writes into memories
   always_ff @(posedge clock) begin
      if (req_acc) begin
         case (op_type'(req_operation))
            OP_DESC: dmem[req_layer] <= '{relu: req_is_relu,
               size: (req_out_size == '0) ? LenW'(1) :
                     (req_out_size > 7'(MaxDim)) ? LenW'(MaxDim) : req_out_size};
            OP_WEIGHT: wmem[{req_layer, req_row, req_col}] <= req_value;
            OP_BIAS:   bmem[{req_layer, req_col}] <= req_value;
            OP_ELEM:   vin[req_row] <= req_value;
            default: ;
         endcase
      end
   end

   // synchronous reads into registers
   always_ff @(posedge clock) begin
      wrd_ff <= wmem[{lay_ff[LayW-1:0], i_ff[DimW-1:0], j_ff[DimW-1:0]}];
      vrd_ff <= va[i_ff[DimW-1:0]];
      brd_ff <= bmem[{lay_ff[LayW-1:0], j_ff[DimW-1:0]}];
   end

   // staged and next vector reads for the copy and the swap, written back in the cycle after
   always_ff @(posedge clock) begin
      vin_rd_ff <= vin[i_ff[DimW-1:0]];
      vb_rd_ff  <= vb[i_ff[DimW-1:0]];
      cpa_ff    <= i_ff[DimW-1:0];
      cpsel_ff  <= (st_ff == S_COPY);
   end

   always_ff @(posedge clock) begin
      if (reset) cpv_ff <= 1'b0;
      else cpv_ff <= (st_ff == S_COPY) || (st_ff == S_SWAP);
   end

   // working vector: copy-in from staging, swap from next
   always_ff @(posedge clock) begin
      if (cpv_ff) va[cpa_ff] <= cpsel_ff ? vin_rd_ff : vb_rd_ff;
      if (vb_we) vb[vb_wa] <= vb_wd;
   end

   // multiply stage
   always_ff @(posedge clock) begin
      prod_ff <= wrd_ff * vrd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; prod_v_ff <= 1'b0; len_ff <= '0;
      end else begin
         st_ff <= st_in; prod_v_ff <= prod_v_in; len_ff <= len_in;
      end
      lay_ff <= lay_in; n_ff <= n_in; i_ff <= i_in; j_ff <= j_in;
      ph_ff <= ph_in; acc_ff <= acc_in;
   end

   // sequencer
   always_comb begin
      st_in = st_ff; len_in = len_ff; lay_in = lay_ff; n_in = n_ff;
      i_in = i_ff; j_in = j_ff; ph_in = ph_ff;
      acc_in = acc_ff; prod_v_in = pv1_ff;
      vb_we = 1'b0; vb_wa = j_ff[DimW-1:0]; vb_wd = '0;
      if (prod_v_ff) acc_in = acc_ff + AccW'(prod_ff);
      case (st_ff)
         S_IDLE: begin
            if (req_acc && op_type'(req_operation) == OP_ELEM && req_last) begin
               len_in = LenW'(req_row) + LenW'(1);
               lay_in = (LayW+1)'(req_layer);
               i_in = '0;
               if ((LayW+1)'(req_layer) < cnt_used) st_in = S_COPY;
            end
         end
         S_COPY: begin
            i_in = i_ff + 1'b1;
            if (i_ff == LenW'(MaxDim-1)) st_in = S_LAYER;
         end
         S_LAYER: begin
            i_in = '0; j_in = '0; acc_in = '0; ph_in = '0;
            if (lay_ff >= cnt_used) begin
               st_in = S_EMIT; j_in = '0;
            end else begin
               n_in = dmem[lay_ff[LayW-1:0]].size;
               st_in = dmem[lay_ff[LayW-1:0]].relu ? S_RELU : S_MAC;
            end
         end
         S_MAC: begin
            // issue reads for row i; the product follows through the read registers and prod_ff
            if (i_ff < len_ff) begin
               i_in = i_ff + 1'b1;
            end
            if (i_ff == len_ff) begin
               st_in = S_FIN; ph_in = 2'd0;
            end
         end
         S_FIN: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd2) begin
               vb_we = 1'b1;
               vb_wd = sat32((acc_ff >>> FracBits) + AccW'(brd_ff));
               acc_in = '0; i_in = '0; j_in = j_ff + 1'b1;
               st_in = (j_ff + 1'b1 == n_ff) ? S_SWAP : S_MAC;
               if (j_ff + 1'b1 == n_ff) begin
                  len_in = n_ff; i_in = '0;
               end
            end
         end
         S_RELU: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd0) i_in = i_ff;
            else begin
               vb_we = 1'b1; vb_wa = i_ff[DimW-1:0];
               vb_wd = vrd_ff[31] ? '0 : vrd_ff;
               i_in = i_ff + 1'b1; ph_in = 2'd0;
               if (i_ff + 1'b1 == len_ff) begin
                  st_in = S_SWAP; i_in = '0;
               end
            end
         end
         S_SWAP: begin
            i_in = i_ff + 1'b1;
            if (i_ff == LenW'(MaxDim-1)) begin
               st_in = S_LAYER; lay_in = lay_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!rv_ff || !rsp_stall) begin
               j_in = j_ff + 1'b1;
               if (j_ff + 1'b1 == len_ff) st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // first stage of the product valid pipeline, aligned to the read registers
   always_ff @(posedge clock) begin
      if (reset) pv1_ff <= 1'b0;
      else pv1_ff <= (st_ff == S_MAC && i_ff < len_ff);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (st_ff == S_EMIT && (!rv_ff || !rsp_stall)) rv_ff <= 1'b1;
      else if (!rsp_stall) rv_ff <= 1'b0;
      if (st_ff == S_EMIT && (!rv_ff || !rsp_stall)) begin
         ri_ff <= j_ff[DimW-1:0];
         rr_ff <= va[j_ff[DimW-1:0]];
         rf_ff <= (j_ff + 1'b1 == len_ff);
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_index = ri_ff;
   assign rsp_result = rr_ff;
   assign rsp_final_res = rf_ff;
endmodule

// ----------------------------------------------------------------------------
// mlp_forward_pass_checker: port protocol checks for the inference engine
// Watches the request and response handshakes over time.
// ----------------------------------------------------------------------------
module mlp_forward_pass_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [5:0]         rsp_index,
   input logic signed [31:0] rsp_result,
   input logic               rsp_final_res
);
   // hold a stalled response transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_index) &&
         $stable(rsp_result) && $stable(rsp_final_res));

   // come out of reset ready for requests
   assert property (@(posedge clock) $fell(reset) |-> !req_stall);

   // keep response valid known
   assert property (@(posedge clock) disable iff (reset) !$isunknown(rsp_valid));

   // block requests while a result vector is still draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> req_stall);
endmodule

bind mlp_forward_pass mlp_forward_pass_checker u_checker (.*);

// ----- sim/mlp_forward_pass_tb.sv -----
// ----------------------------------------------------------------------------
// mlp_forward_pass_tb: self-checking bench for the MLP inference engine
// Preloads small layers, then drives directed and random load, element and
// run transactions under varying layer counts and handshake pressure. A
// scoreboard class predicts every output element and compares in order.
// ----------------------------------------------------------------------------
module mlp_forward_pass_tb;
   import mlp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Dim       = 4;        // largest working size of any layer
   localparam int Limit     = 600000;
   localparam int SettleCyc = 100;

   typedef struct {
      op_type      op;
      logic [2:0]  layer;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [31:0] value;
      logic        is_relu;
      logic [6:0]  out_size;
      logic        last;
   } req_type;

   typedef struct {
      logic [5:0]  index;
      logic [31:0] result;
      logic        final_res;
   } elem_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = '0;
   logic [2:0]         req_layer = '0;
   logic [5:0]         req_row = '0;
   logic [5:0]         req_col = '0;
   logic signed [31:0] req_value = '0;
   logic               req_is_relu = 1'b0;
   logic [6:0]         req_out_size = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [5:0]         rsp_index;
   logic signed [31:0] rsp_result;
   logic               rsp_final_res;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_layer_count = '0;

   int errors    = 0;
   int cycles    = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_req  = 0;

   mlp_forward_pass u_top (.*);

   always #5 clock = ~clock;

   task automatic report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Predicts the output vector of each run and holds it until it drains
   class mlp_scoreboard;
      logic [31:0] wt[MaxLayers][MaxDim][MaxDim];
      logic [31:0] bs[MaxLayers][MaxDim];
      logic        relu_tab[MaxLayers];
      int          size_tab[MaxLayers];
      logic [31:0] staged[MaxDim];
      int          in_len;
      int          lcount;
      elem_type    out_q[$];

      function new();
         in_len = 0;
         lcount = 1;
      endfunction

      function void set_count(logic [3:0] v);
         lcount = v;
      endfunction

      function int pending();
         return out_q.size();
      endfunction

      function logic [31:0] dot_bias(logic [31:0] v[MaxDim], int len, int l, int j);
         logic signed [127:0] acc;
         longint              p;
         acc = '0;
         for (int i = 0; i < len; i++) begin
            p = longint'($signed(v[i])) * longint'($signed(wt[l][i][j]));
            acc = acc + p;
         end
         acc = acc >>> FracBits;
         acc = acc + $signed(bs[l][j]);
         if (acc > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
         if (acc < -128'sh80000000) return 32'h80000000;
         return acc[31:0];
      endfunction

      function void note(req_type t);
         logic [31:0] v[MaxDim];
         logic [31:0] nxt[MaxDim];
         int          cnt, len, n;
         elem_type    e;
         case (t.op)
            OP_DESC: begin
               n = t.out_size;
               if (n == 0) n = 1;
               if (n > MaxDim) n = MaxDim;
               relu_tab[t.layer] = t.is_relu;
               size_tab[t.layer] = n;
            end
            OP_WEIGHT: wt[t.layer][t.row][t.col] = t.value;
            OP_BIAS:   bs[t.layer][t.col] = t.value;
            OP_ELEM: begin
               staged[t.row] = t.value;
               if (t.last) begin
                  in_len = t.row + 1;
                  cnt = (lcount > MaxLayers) ? MaxLayers : lcount;
                  if (t.layer < cnt) begin
                     len = in_len;
                     v = staged;
                     for (int l = t.layer; l < cnt; l++) begin
                        if (relu_tab[l]) begin
                           for (int j = 0; j < len; j++)
                              if (v[j][31]) v[j] = '0;
                        end else begin
                           for (int j = 0; j < size_tab[l]; j++)
                              nxt[j] = dot_bias(v, len, l, j);
                           for (int j = 0; j < size_tab[l]; j++) v[j] = nxt[j];
                           len = size_tab[l];
                        end
                     end
                     for (int j = 0; j < len; j++) begin
                        e.index = 6'(j);
                        e.result = v[j];
                        e.final_res = (j == len - 1);
                        out_q.push_back(e);
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task check(logic [5:0] idx, logic [31:0] res, logic fin);
         elem_type e;
         if (out_q.size() == 0) begin
            report($sformatf("unexpected element idx=%0d val=%h", idx, res));
            return;
         end
         e = out_q.pop_front();
         if (idx !== e.index)
            report($sformatf("index %0d, want %0d", idx, e.index));
         if (res !== e.result)
            report($sformatf("element %0d value %h, want %h", e.index, res, e.result));
         if (fin !== e.final_res)
            report($sformatf("element %0d last flag %b, want %b", e.index, fin,
                             e.final_res));
      endtask
   endclass

   mlp_scoreboard book = new();

   // Abort on a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > Limit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Drive receiver backpressure; honor a long hold when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req > 0) begin
         rsp_stall <= 1'b1;
         hold_req--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Check each accepted output transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check(rsp_index, rsp_result, rsp_final_res);
   end

   // Send one transaction; entered and left at a falling edge
   task automatic send_req(input req_type t);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= t.op;
      req_layer     <= t.layer;
      req_row       <= t.row;
      req_col       <= t.col;
      req_value     <= t.value;
      req_is_relu   <= t.is_relu;
      req_out_size  <= t.out_size;
      req_last      <= t.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note(t);
      @(negedge clock);
   endtask

   function automatic req_type mk(op_type op, int lay, int row, int col, logic [31:0] val,
                                  int relu = 0, int osz = 1, int last = 0);
      req_type t;
      t.op = op; t.layer = 3'(lay); t.row = 6'(row); t.col = 6'(col); t.value = val;
      t.is_relu = 1'(relu); t.out_size = 7'(osz); t.last = 1'(last);
      return t;
   endfunction

   function automatic logic [31:0] rand_val();
      if ($urandom_range(1)) return $urandom();
      return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
   endfunction

   // Stage a vector of len elements and start a run from layer lay if it is below the layer count
   task automatic run_vec(input int lay, input int len, input logic [31:0] fixed = 'x);
      for (int i = 0; i < len; i++)
         send_req(mk(OP_ELEM, lay, i, $urandom_range(63),
                     (fixed === 'x) ? rand_val() : fixed, $urandom_range(1),
                     $urandom_range(127), i == len - 1));
   endtask

   // Drain outstanding elements, let the engine settle, then write the count
   task automatic set_layers(input logic [3:0] v);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (SettleCyc) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_layer_count <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.set_count(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         run_vec($urandom_range(7), $urandom_range(1, Dim));
      end else if (pick < 75) begin
         if ($urandom_range(9) == 0)
            send_req(mk(OP_WEIGHT, $urandom_range(7), $urandom_range(63),
                        $urandom_range(63), rand_val()));
         else
            send_req(mk(OP_WEIGHT, $urandom_range(7), $urandom_range(Dim - 1),
                        $urandom_range(Dim - 1), rand_val()));
      end else if (pick < 87) begin
         send_req(mk(OP_BIAS, $urandom_range(7), $urandom_range(63),
                     ($urandom_range(9) == 0) ? $urandom_range(63)
                                              : $urandom_range(Dim - 1), rand_val()));
      end else if (pick < 94) begin
         send_req(mk(OP_DESC, $urandom_range(7), $urandom_range(63), $urandom_range(63),
                     $urandom(), $urandom_range(1), $urandom_range(0, Dim)));
      end else begin
         // stray staged element, never last
         send_req(mk(OP_ELEM, $urandom_range(7), $urandom_range(63), $urandom_range(63),
                     $urandom(), $urandom_range(1), $urandom_range(127), 0));
      end
   endtask

   initial begin
      logic [3:0] counts[6];
      counts = '{4'd15, 4'd3, 4'd0, 4'd1, 4'd8, 4'd0};
      counts[5] = 4'($urandom_range(1, 8));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // preload every layer's weights and biases at the working size, sizes up to it
      for (int l = 0; l < MaxLayers; l++) begin
         send_req(mk(OP_DESC, l, 0, 0, '0, $urandom_range(3) == 0, $urandom_range(1, Dim)));
         for (int c = 0; c < Dim; c++) begin
            send_req(mk(OP_BIAS, l, 0, c, rand_val()));
            for (int r = 0; r < Dim; r++)
               send_req(mk(OP_WEIGHT, l, r, c, rand_val()));
         end
      end

      // directed: full-length vector with the first layer beyond the default count
      send_req(mk(OP_ELEM, 5, 63, 0, 32'h80000000, 0, 0, 1));
      run_vec(0, Dim);
      set_layers(4'd8);
      // descriptor size extremes, then restore layer 7
      send_req(mk(OP_DESC, 7, 0, 0, '0, 0, 127));
      send_req(mk(OP_DESC, 7, 0, 0, '0, 1, 0));
      send_req(mk(OP_DESC, 7, 0, 0, '0, 0, 64));
      send_req(mk(OP_DESC, 7, 0, 0, '0, 0, Dim));
      send_req(mk(OP_WEIGHT, 7, 63, 63, 32'h7FFFFFFF));
      send_req(mk(OP_BIAS, 7, 63, 63, 32'h80000000));
      send_req(mk(OP_ELEM, 7, 63, 63, 32'h7FFFFFFF, 1, 127, 0));
      // saturating run through the last layer
      send_req(mk(OP_WEIGHT, 7, 0, 0, 32'h7FFFFFFF));
      run_vec(7, Dim, 32'h7FFFFFFF);
      run_vec(7, Dim, 32'h80000000);
      // ReLU layer on negative and positive elements
      send_req(mk(OP_DESC, 6, 0, 0, '0, 1, Dim));
      run_vec(6, 2, 32'hFFFF0000);
      run_vec(6, 1, 32'h00010000);
      run_vec(0, 1);

      // random phases, one layer count each
      for (int ph = 0; ph < 6; ph++) begin
         set_layers(counts[ph]);
         for (int k = 0; k < 8; k++) begin
            if (ph < 2) begin
               send_idle = 25; recv_idle = 77;
            end else if (ph < 4) begin
               send_idle = 77; recv_idle = 25;
            end else begin
               send_idle = 0; recv_idle = 0;
            end
            if (ph == 4 && k == 5) hold_req = 400;
            random_item();
         end
      end

      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (SettleCyc) @(negedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ----- mlp_forward_pass.f -----
design/mlp_pkg.sv
design/mlp_forward_pass.sv
sim/mlp_forward_pass_tb.sv
